// File: rtl/pdbf_pkg.sv
// Shared types, codes and the blend-mode decoder for the Porter-Duff blend filter.
`timescale 1ns / 1ps

package pdbf_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PROD_W  = 2 * CHAN_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned QUOT_W  = CHAN_W + 1;
  localparam int unsigned TOTAL_W = CHAN_W + 2;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned IDX_W   = 3;

  localparam logic [CHAN_W-1:0] FULL = 8'd255;

  // Blend mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 4'd0,
    MODE_SRC     = 4'd1,
    MODE_DST     = 4'd2,
    MODE_SRCOVER = 4'd3,
    MODE_DSTOVER = 4'd4,
    MODE_SRCIN   = 4'd5,
    MODE_DSTIN   = 4'd6,
    MODE_SRCOUT  = 4'd7,
    MODE_DSTOUT  = 4'd8,
    MODE_SRCATOP = 4'd9,
    MODE_DSTATOP = 4'd10,
    MODE_XOR     = 4'd11
  } mode_t;

  localparam mode_t MODE_RESET = MODE_SRCOVER;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_BLEND_MODE = 3'd0,
    REG_SRC_ALPHA  = 3'd1,
    REG_SRC_RED    = 3'd2,
    REG_SRC_GREEN  = 3'd3,
    REG_SRC_BLUE   = 3'd4
  } reg_idx_t;

  // Factor applied to the source channel
  typedef enum logic [1:0] {
    M0_ZERO = 2'd0,
    M0_DA   = 2'd1,
    M0_IDA  = 2'd2
  } m0_sel_t;

  // Factor applied to the destination channel
  typedef enum logic [1:0] {
    M1_ZERO = 2'd0,
    M1_SA   = 2'd1,
    M1_ISA  = 2'd2
  } m1_sel_t;

  // Term added after the divide
  typedef enum logic [1:0] {
    ADD_ZERO = 2'd0,
    ADD_S    = 2'd1,
    ADD_D    = 2'd2
  } add_sel_t;

  typedef struct packed {
    m0_sel_t  m0_sel;
    m1_sel_t  m1_sel;
    add_sel_t add_sel;
  } lane_ctrl_t;

  // Per-lane control: result = add + (s*m0 + d*m1) / 255
  function automatic lane_ctrl_t decode_mode(input logic [MODE_W-1:0] mode,
                                             input logic is_alpha);
    lane_ctrl_t c;
    c.m0_sel  = M0_ZERO;
    c.m1_sel  = M1_ZERO;
    c.add_sel = ADD_ZERO;
    case (mode)
      MODE_CLEAR: begin
      end
      MODE_SRC: begin
        c.add_sel = ADD_S;
      end
      MODE_DST: begin
        c.add_sel = ADD_D;
      end
      MODE_SRCOVER: begin
        c.add_sel = ADD_S;
        c.m1_sel  = M1_ISA;
      end
      MODE_DSTOVER: begin
        c.add_sel = ADD_D;
        c.m0_sel  = M0_IDA;
      end
      MODE_SRCIN: begin
        c.m0_sel = M0_DA;
      end
      MODE_DSTIN: begin
        c.m1_sel = M1_SA;
      end
      MODE_SRCOUT: begin
        c.m0_sel = M0_IDA;
      end
      MODE_DSTOUT: begin
        c.m1_sel = M1_ISA;
      end
      MODE_SRCATOP: begin
        if (is_alpha) begin
          c.add_sel = ADD_D;
        end else begin
          c.m0_sel = M0_DA;
          c.m1_sel = M1_ISA;
        end
      end
      MODE_DSTATOP: begin
        if (is_alpha) begin
          c.add_sel = ADD_S;
        end else begin
          c.m0_sel = M0_IDA;
          c.m1_sel = M1_SA;
        end
      end
      default: begin
        // xor, and the unused codes behave the same
        c.m0_sel = M0_IDA;
        c.m1_sel = M1_ISA;
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/porter_duff_blend_filter.sv
// Top level of the Porter-Duff blend filter: config registers, valid pipeline, four lanes.
//
// Blends one premultiplied source color, held in registers, over a stream of
// premultiplied ARGB8888 destination pixels, one result item per input item.
// Input channel: in_valid / in_stall with dst_alpha, dst_red, dst_green,
// dst_blue and end_of_run. Output channel: out_valid / out_stall with
// out_alpha, out_red, out_green, out_blue and end_of_run_out.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// 0 blend_mode, 1 src_alpha, 2 src_red, 3 src_green, 4 src_blue; other
// indexes are ignored. Write config only while no item is in flight.
// One item per cycle sustained while out_stall does not hold a result, set by the
// three-stage multiply / divide-by-255 / saturate pipeline.
// Reset sets blend_mode to src-over, the source color to zero and empties the
// pipeline. While out_stall holds a valid result, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps

module porter_duff_blend_filter
  import pdbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // config write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CHAN_W-1:0] cfg_data,
  // input pixel channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] dst_alpha,
  input  logic [CHAN_W-1:0] dst_red,
  input  logic [CHAN_W-1:0] dst_green,
  input  logic [CHAN_W-1:0] dst_blue,
  input  logic              end_of_run,
  // output pixel channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_alpha,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic              end_of_run_out
);

  // Configuration registers
  logic [MODE_W-1:0] blend_mode;
  logic [CHAN_W-1:0] src_alpha;
  logic [CHAN_W-1:0] src_red;
  logic [CHAN_W-1:0] src_green;
  logic [CHAN_W-1:0] src_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_RESET;
      src_alpha  <= '0;
      src_red    <= '0;
      src_green  <= '0;
      src_blue   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLEND_MODE: blend_mode <= cfg_data[MODE_W-1:0];
        REG_SRC_ALPHA:  src_alpha  <= cfg_data;
        REG_SRC_RED:    src_red    <= cfg_data;
        REG_SRC_GREEN:  src_green  <= cfg_data;
        REG_SRC_BLUE:   src_blue   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline advance: freeze everything while a result waits on the receiver
  logic en;
  logic v1;
  logic v2;
  logic v3;
  logic eor1;
  logic eor2;

  assign en       = !(v3 && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Run marker rides along with the pixel
  always_ff @(posedge clk) begin
    if (en) begin
      eor1           <= end_of_run;
      eor2           <= eor1;
      end_of_run_out <= eor2;
    end
  end

  assign out_valid = v3;

  // Lane controls from the current mode
  lane_ctrl_t ctrl_alpha;
  lane_ctrl_t ctrl_color;

  assign ctrl_alpha = decode_mode(blend_mode, 1'b1);
  assign ctrl_color = decode_mode(blend_mode, 1'b0);

  pdbf_lane u_lane_alpha (
    .clk    (clk),
    .en     (en),
    .ctrl   (ctrl_alpha),
    .s      (src_alpha),
    .d      (dst_alpha),
    .sa     (src_alpha),
    .da     (dst_alpha),
    .result (out_alpha)
  );

  pdbf_lane u_lane_red (
    .clk    (clk),
    .en     (en),
    .ctrl   (ctrl_color),
    .s      (src_red),
    .d      (dst_red),
    .sa     (src_alpha),
    .da     (dst_alpha),
    .result (out_red)
  );

  pdbf_lane u_lane_green (
    .clk    (clk),
    .en     (en),
    .ctrl   (ctrl_color),
    .s      (src_green),
    .d      (dst_green),
    .sa     (src_alpha),
    .da     (dst_alpha),
    .result (out_green)
  );

  pdbf_lane u_lane_blue (
    .clk    (clk),
    .en     (en),
    .ctrl   (ctrl_color),
    .s      (src_blue),
    .d      (dst_blue),
    .sa     (src_alpha),
    .da     (dst_alpha),
    .result (out_blue)
  );

`ifndef SYNTHESIS
  // An accepted item occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted item missing from stage 1");

  // A stalled result is not lost
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  // A taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v2) |=> !out_valid)
    else $error("result repeated after drain");
`endif

endmodule

// File: rtl/pdbf_lane.sv
// One color or alpha lane: multiply, divide by 255, add and saturate in three stages.
`timescale 1ns / 1ps

module pdbf_lane
  import pdbf_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  lane_ctrl_t        ctrl,
  input  logic [CHAN_W-1:0] s,
  input  logic [CHAN_W-1:0] d,
  input  logic [CHAN_W-1:0] sa,
  input  logic [CHAN_W-1:0] da,
  output logic [CHAN_W-1:0] result
);

  // Stage 1: operand select and the two products
  logic [CHAN_W-1:0] m0;
  logic [CHAN_W-1:0] m1;
  logic [CHAN_W-1:0] add_val;
  logic [PROD_W-1:0] p0;
  logic [PROD_W-1:0] p1;
  logic [CHAN_W-1:0] add1;

  always_comb begin
    case (ctrl.m0_sel)
      M0_DA:   m0 = da;
      M0_IDA:  m0 = FULL - da;
      default: m0 = '0;
    endcase
    case (ctrl.m1_sel)
      M1_SA:   m1 = sa;
      M1_ISA:  m1 = FULL - sa;
      default: m1 = '0;
    endcase
    case (ctrl.add_sel)
      ADD_S:   add_val = s;
      ADD_D:   add_val = d;
      default: add_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= PROD_W'(s) * PROD_W'(m0);
      p1   <= PROD_W'(d) * PROD_W'(m1);
      add1 <= add_val;
    end
  end

  // Stage 2: sum and quotient estimate (x + x/256) / 256, low by at most one
  logic [SUM_W-1:0]  x_next;
  logic [SUM_W-1:0]  est_sum;
  logic [SUM_W-1:0]  x2;
  logic [QUOT_W-1:0] q2;
  logic [CHAN_W-1:0] add2;

  assign x_next  = SUM_W'(p0) + SUM_W'(p1);
  assign est_sum = x_next + (x_next >> CHAN_W);

  always_ff @(posedge clk) begin
    if (en) begin
      x2   <= x_next;
      q2   <= est_sum[SUM_W-1:CHAN_W];
      add2 <= add1;
    end
  end

  // Stage 3: one-step correction, add term and saturate
  logic [SUM_W-1:0]   rem;
  logic [QUOT_W-1:0]  q_fix;
  logic [TOTAL_W-1:0] total;

  assign rem   = x2 - ((SUM_W'(q2) << CHAN_W) - SUM_W'(q2));
  assign q_fix = q2 + QUOT_W'(rem >= SUM_W'(FULL));
  assign total = TOTAL_W'(add2) + TOTAL_W'(q_fix);

  always_ff @(posedge clk) begin
    if (en) begin
      result <= (total > TOTAL_W'(FULL)) ? FULL : total[CHAN_W-1:0];
    end
  end

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the Porter-Duff blend filter: scoreboard class, drivers, stimulus.
`timescale 1ns / 1ps

module testbench
  import pdbf_pkg::*;
();

  localparam int unsigned CH_MAX = FULL;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              eor;
  } pixel_t;

  // Holds a copy of the blend registers and the queue of blended pixels still due
  class blend_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] src_a, src_r, src_g, src_b;
    pixel_t            blended_q[$];
    int unsigned       errors;

    function new();
      mode   = MODE_RESET;
      src_a  = '0;
      src_r  = '0;
      src_g  = '0;
      src_b  = '0;
      errors = 0;
    endfunction

    // register write; indexes past the last register are dropped
    function void write_reg(logic [IDX_W-1:0] idx, logic [CHAN_W-1:0] data);
      case (idx)
        REG_BLEND_MODE: mode  = data[MODE_W-1:0];
        REG_SRC_ALPHA:  src_a = data;
        REG_SRC_RED:    src_r = data;
        REG_SRC_GREEN:  src_g = data;
        REG_SRC_BLUE:   src_b = data;
        default: ;
      endcase
    endfunction

    // one lane: s, d channel values; sa, da the alphas; truncating /255, then clamp
    function int unsigned blend_chan(int unsigned s, int unsigned d,
                                     int unsigned sa, int unsigned da);
      int unsigned isa, ida, v;
      isa = CH_MAX - sa;
      ida = CH_MAX - da;
      case (mode)
        MODE_CLEAR:   v = 0;
        MODE_SRC:     v = s;
        MODE_DST:     v = d;
        MODE_SRCOVER: v = s + isa * d / CH_MAX;
        MODE_DSTOVER: v = d + ida * s / CH_MAX;
        MODE_SRCIN:   v = s * da / CH_MAX;
        MODE_DSTIN:   v = d * sa / CH_MAX;
        MODE_SRCOUT:  v = ida * s / CH_MAX;
        MODE_DSTOUT:  v = isa * d / CH_MAX;
        MODE_SRCATOP: v = (s * da + isa * d) / CH_MAX;
        MODE_DSTATOP: v = (d * sa + ida * s) / CH_MAX;
        default:      v = (ida * s + isa * d) / CH_MAX;  // xor and unused codes
      endcase
      return (v > CH_MAX) ? CH_MAX : v;
    endfunction

    // accepted destination pixel: queue the blended pixel it must produce
    function void note_input(pixel_t d);
      pixel_t p;
      if (mode == MODE_SRCATOP) begin
        p.alpha = d.alpha;
      end else if (mode == MODE_DSTATOP) begin
        p.alpha = src_a;
      end else begin
        p.alpha = CHAN_W'(blend_chan(src_a, d.alpha, src_a, d.alpha));
      end
      p.red   = CHAN_W'(blend_chan(src_r, d.red, src_a, d.alpha));
      p.green = CHAN_W'(blend_chan(src_g, d.green, src_a, d.alpha));
      p.blue  = CHAN_W'(blend_chan(src_b, d.blue, src_a, d.alpha));
      p.eor   = d.eor;
      blended_q.push_back(p);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // accepted output item: compare with the oldest blended pixel due
    function void check_result(pixel_t got);
      pixel_t want;
      if (blended_q.size() == 0) begin
        $display("%0t: output item with none expected, actual a=%0d r=%0d g=%0d b=%0d eor=%0d",
                 $time, got.alpha, got.red, got.green, got.blue, got.eor);
        errors++;
        return;
      end
      want = blended_q.pop_front();
      cmp_field("out_alpha", want.alpha, got.alpha);
      cmp_field("out_red", want.red, got.red);
      cmp_field("out_green", want.green, got.green);
      cmp_field("out_blue", want.blue, got.blue);
      cmp_field("end_of_run_out", want.eor, got.eor);
    endfunction

    function int pending();
      return blended_q.size();
    endfunction
  endclass

  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned BLOCKS       = 8;
  localparam int unsigned BLOCK_ITEMS  = 60;
  localparam int unsigned REG_COUNT    = 5;
  localparam int unsigned TIMEOUT_NS   = 2000000;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_valid  = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [CHAN_W-1:0] cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic [CHAN_W-1:0] dst_alpha  = '0;
  logic [CHAN_W-1:0] dst_red    = '0;
  logic [CHAN_W-1:0] dst_green  = '0;
  logic [CHAN_W-1:0] dst_blue   = '0;
  logic              end_of_run = 1'b0;
  logic              out_stall  = 1'b0;
  logic              cfg_ready;
  logic              in_stall;
  logic              out_valid;
  logic [CHAN_W-1:0] out_alpha, out_red, out_green, out_blue;
  logic              end_of_run_out;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  blend_scoreboard board;

  porter_duff_blend_filter dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .dst_alpha      (dst_alpha),
    .dst_red        (dst_red),
    .dst_green      (dst_green),
    .dst_blue       (dst_blue),
    .end_of_run     (end_of_run),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_alpha      (out_alpha),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .end_of_run_out (end_of_run_out)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // monitor both channels
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      board.note_input({dst_alpha, dst_red, dst_green, dst_blue, end_of_run});
    end
    if (!rst && out_valid && !out_stall) begin
      board.check_result({out_alpha, out_red, out_green, out_blue, end_of_run_out});
    end
  end

  function automatic logic [CHAN_W-1:0] rand_chan();
    logic [CHAN_W-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = FULL;
      default: v = CHAN_W'($urandom_range(CH_MAX));
    endcase
    return v;
  endfunction

  function automatic pixel_t make_pixel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] r,
                                        logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                                        logic e);
    pixel_t p;
    p.alpha = a;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.eor   = e;
    return p;
  endfunction

  // mostly premultiplied pixels, some with color above alpha
  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.alpha = rand_chan();
    if ($urandom_range(99) < 80) begin
      p.red   = CHAN_W'($urandom_range(p.alpha));
      p.green = CHAN_W'($urandom_range(p.alpha));
      p.blue  = CHAN_W'($urandom_range(p.alpha));
    end else begin
      p.red   = rand_chan();
      p.green = rand_chan();
      p.blue  = rand_chan();
    end
    p.eor = ($urandom_range(15) == 0);
    return p;
  endfunction

  // offer one pixel, with random idle cycles first; in_valid stays high afterwards
  task automatic push_pixel(input pixel_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    {dst_alpha, dst_red, dst_green, dst_blue, end_of_run} <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every blended pixel is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; cfg_valid is left high for the caller to drop
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CHAN_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  // program mode and source color; upper mode bits get junk, optional stray index
  task automatic set_source(input logic [MODE_W-1:0] m, input logic [CHAN_W-1:0] a,
                            input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input bit stray);
    logic [CHAN_W-1:0] mode_data;
    mode_data = CHAN_W'($urandom_range(CH_MAX));
    mode_data[MODE_W-1:0] = m;
    cfg_write(REG_BLEND_MODE, mode_data);
    cfg_write(REG_SRC_ALPHA, a);
    cfg_write(REG_SRC_RED, r);
    cfg_write(REG_SRC_GREEN, g);
    cfg_write(REG_SRC_BLUE, b);
    if (stray) begin
      cfg_write(IDX_W'($urandom_range(2**IDX_W - 1, REG_COUNT)),
                CHAN_W'($urandom_range(CH_MAX)));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_random_source();
    logic [MODE_W-1:0] m;
    logic [CHAN_W-1:0] a;
    bit                stray;
    if ($urandom_range(9) == 0) begin
      m = MODE_W'($urandom_range(2**MODE_W - 1, MODE_XOR + 1));
    end else begin
      m = MODE_W'($urandom_range(MODE_XOR));
    end
    a = rand_chan();
    stray = ($urandom_range(3) == 0);
    if ($urandom_range(99) < 80) begin
      set_source(m, a, CHAN_W'($urandom_range(a)), CHAN_W'($urandom_range(a)),
                 CHAN_W'($urandom_range(a)), stray);
    end else begin
      set_source(m, a, rand_chan(), rand_chan(), rand_chan(), stray);
    end
  endtask

  // main sequence
  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: src-over with a transparent black source
    push_pixel(make_pixel('0, '0, '0, '0, 1'b0));
    push_pixel(make_pixel(FULL, FULL, FULL, FULL, 1'b1));
    wait_drained();

    // every mode code, unused ones too; source and pixel not premultiplied
    for (int m = 0; m < 2**MODE_W; m++) begin
      set_source(MODE_W'(m), 8'd100, FULL, '0, 8'd100, 1'b0);
      push_pixel(make_pixel(8'd60, FULL, '0, 8'd30, m[0]));
      wait_drained();
    end

    // opaque white source, followed by a write to an unused index
    set_source(MODE_SRCOVER, FULL, FULL, FULL, FULL, 1'b1);
    push_pixel(make_pixel('0, '0, '0, '0, 1'b0));
    push_pixel(make_pixel(FULL, FULL, FULL, FULL, 1'b1));
    wait_drained();

    // random part: three idle patterns, fresh settings per block
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct <= 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct <= 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        pick_random_source();
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          // long receiver hold-off while the sender keeps going
          if (ph == 2 && blk == 3 && n == 5) begin
            hold_req <= hold_req + 1;
          end
          // sender pauses until the pipeline is empty
          if (ph == 1 && blk == 4 && n == 30) begin
            wait_drained();
          end
          push_pixel(rand_pixel());
        end
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

endmodule

// File: porter_duff_blend_filter.f
rtl/pdbf_pkg.sv
rtl/pdbf_lane.sv
rtl/porter_duff_blend_filter.sv
bench/testbench.sv
